[hdl/aes128_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 package
// Shared types, constants and byte-level functions for the AES-128 pipeline.
// ----------------------------------------------------------------------------
package aes128_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned CfgIdxW   = 8;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_HIGH = 8'd0,
    REG_KEY_LOW  = 8'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
  } in_word_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } out_word_t;

  localparam logic [7:0] GfReduce = 8'h1b;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [NumRounds+1] = '{
    8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  // Byte i of a block sits at bits [127-8i -: 8].
  function automatic logic [7:0] get_byte(input logic [127:0] b, input int unsigned i);
    get_byte = b[127-8*i -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? GfReduce : 8'h00);
  endfunction

  function automatic logic [127:0] subst_state(input logic [127:0] s);
    logic [127:0] r;
    for (int i = 0; i < 16; i++) begin
      r[127-8*i -: 8] = SBOX[s[127-8*i -: 8]];
    end
    subst_state = r;
  endfunction

  function automatic logic [127:0] rotate_state_rows(input logic [127:0] s);
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int w = 0; w < 4; w++) begin
        r[127-8*(4*c+w) -: 8] = s[127-8*(4*((c+w)%4)+w) -: 8];
      end
    end
    rotate_state_rows = r;
  endfunction

  function automatic logic [127:0] mix_state_cols(input logic [127:0] s);
    logic [127:0] r;
    logic [7:0] a0, a1, a2, a3, t;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-8*(4*c)   -: 8];
      a1 = s[127-8*(4*c+1) -: 8];
      a2 = s[127-8*(4*c+2) -: 8];
      a3 = s[127-8*(4*c+3) -: 8];
      t  = a0 ^ a1 ^ a2 ^ a3;
      r[127-8*(4*c)   -: 8] = a0 ^ t ^ xtime(a0 ^ a1);
      r[127-8*(4*c+1) -: 8] = a1 ^ t ^ xtime(a1 ^ a2);
      r[127-8*(4*c+2) -: 8] = a2 ^ t ^ xtime(a2 ^ a3);
      r[127-8*(4*c+3) -: 8] = a3 ^ t ^ xtime(a3 ^ a0);
    end
    mix_state_cols = r;
  endfunction

  // Next round key from the previous one; rc is the round constant.
  function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    next_key = {w0, w1, w2, w3};
  endfunction

endpackage

[hdl/aes128_round.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 round stage
// One registered round: state and round key advance together.
// ----------------------------------------------------------------------------
module aes128_round (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [3:0]   round_i,
  input  logic         valid_i,
  input  logic [127:0] state_i,
  input  logic [127:0] key_i,
  output logic         valid_o,
  output logic [127:0] state_o,
  output logic [127:0] key_o
);

  logic         valid_q;
  logic [127:0] state_q, state_d;
  logic [127:0] key_q, key_d;
  logic [127:0] shifted;

  always_comb begin
    key_d   = aes128_pkg::next_key(key_i, aes128_pkg::RCON[round_i]);
    shifted = aes128_pkg::rotate_state_rows(aes128_pkg::subst_state(state_i));
    if (round_i == 4'(aes128_pkg::NumRounds)) begin
      state_d = shifted ^ key_d;
    end else begin
      state_d = aes128_pkg::mix_state_cols(shifted) ^ key_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    state_q <= state_d;
    key_q   <= key_d;
  end

  assign valid_o = valid_q;
  assign state_o = state_q;
  assign key_o   = key_q;

endmodule

[hdl/aes128_block_encrypt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 block encryption
// Fully pipelined forward cipher with on-the-fly round key expansion.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// input     in         start / busy         in_i (plain_high, plain_low)
// result    out        strobe_o             out_o (cipher_high, cipher_low)
// config    in         cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// One block is accepted every cycle; busy is always low.
// Each block passes the initial AddRoundKey stage and then the round stages in order.
// Each round stage expands its own round key, so the key travels with its block.
// Reset clears the valid bits and the configured key registers to zero.
// The receiver cannot stall, so the pipeline never holds.
module aes128_block_encrypt (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  aes128_pkg::in_word_t in_i,
  output logic                 strobe_o,
  output aes128_pkg::out_word_t out_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [aes128_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]          cfg_data_i
);

  localparam int unsigned N = aes128_pkg::NumRounds;

  logic [63:0]  key_high_q, key_low_q;
  logic         v   [N+1];
  logic [127:0] st  [N+1];
  logic [127:0] rk  [N+1];
  logic         v0_q;
  logic [127:0] st0_q, rk0_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
      v0_q       <= 1'b0;
    end else begin
      v0_q <= start;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          aes128_pkg::REG_KEY_HIGH: key_high_q <= cfg_data_i;
          aes128_pkg::REG_KEY_LOW:  key_low_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Initial AddRoundKey stage.
  always_ff @(posedge clk_i) begin
    st0_q <= {in_i.plain_high, in_i.plain_low} ^ {key_high_q, key_low_q};
    rk0_q <= {key_high_q, key_low_q};
  end

  assign v[0]  = v0_q;
  assign st[0] = st0_q;
  assign rk[0] = rk0_q;

  for (genvar g = 1; g <= N; g++) begin : g_round
    aes128_round u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .round_i (4'(g)),
      .valid_i (v[g-1]),
      .state_i (st[g-1]),
      .key_i   (rk[g-1]),
      .valid_o (v[g]),
      .state_o (st[g]),
      .key_o   (rk[g])
    );
  end

  assign strobe_o          = v[N];
  assign out_o.cipher_high = st[N][127:64];
  assign out_o.cipher_low  = st[N][63:0];

  // Each result must line up with a block accepted through the initial stage and all round stages.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(start, N + 1))
    else $error("result without matching start");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(start, N + 1) |-> strobe_o)
    else $error("accepted block produced no result");

  // The first round stage must carry the round key expanded from the stage-zero key.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v[1] |-> rk[1] == aes128_pkg::next_key($past(rk0_q), aes128_pkg::RCON[1]))
    else $error("first round key mismatch");

endmodule
